// ----- rtl/egd_pkg.sv -----
package egd_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int ZC_WIDTH    = $clog2(VALUE_WIDTH + 1);
   localparam int BL_WIDTH    = $clog2(VALUE_WIDTH);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [ZC_WIDTH-1:0]    ZC_LIMIT  = ZC_WIDTH'(VALUE_WIDTH - 1);
   localparam logic [VALUE_WIDTH-1:0] VALUE_ONE = VALUE_WIDTH'(1);
   localparam logic [VALUE_WIDTH-1:0] VALUE_TWO = VALUE_WIDTH'(2);

   localparam logic MAP_RAW    = 1'b0;
   localparam logic MAP_OFFSET = 1'b1;
   localparam logic MAP_RESET  = MAP_OFFSET;

   localparam logic [2:0] LAST_POS = 3'd7;

   typedef struct packed {
      logic [7:0] data;
      logic       clear;
      logic [2:0] start_pos;
      logic       last;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

endpackage

// ----- rtl/egd_front.sv -----
module egd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_data_byte,
   input  logic             req_restart,
   input  logic [2:0]       req_start_bit_skip,
   input  logic             req_last_byte,
   output egd_pkg::head_type head,
   input  logic             head_pop
);
   import egd_pkg::*;

   item_type              queue_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0] count_ff, count_in;
   item_type              item_in;
   logic                  accept;
   logic                  pop;

   assign req_stall = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign pop       = head_pop && (count_ff != '0);

   always_comb begin
      item_in.data      = req_data_byte;
      item_in.clear     = req_restart;
      item_in.start_pos = req_restart ? req_start_bit_skip : 3'd0;
      item_in.last      = req_last_byte;
   end

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_WIDTH'(accept) - QCNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= item_in;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = queue_ff[rd_ptr_ff];

endmodule

// ----- rtl/egd_back.sv -----
module egd_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            map_mode,
   input  egd_pkg::head_type               head,
   output logic                            head_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [egd_pkg::VALUE_WIDTH-1:0] rsp_value,
   output logic                            rsp_is_delimiter,
   output logic                            rsp_overflow_error,
   output logic                            rsp_last_of_run
);
   import egd_pkg::*;

   logic                   reading_ff, reading_in;
   logic [ZC_WIDTH-1:0]    zc_ff, zc_in;
   logic [BL_WIDTH-1:0]    bl_ff, bl_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic                   started_ff;
   logic [2:0]             pos_ff;

   logic                   pend_valid_ff;
   logic                   pend_end_ff;
   logic [VALUE_WIDTH-1:0] pend_value_ff;
   logic                   pend_delim_ff;
   logic                   pend_ovf_ff;

   logic                   out_valid_ff;
   logic [VALUE_WIDTH-1:0] out_value_ff;
   logic                   out_delim_ff;
   logic                   out_ovf_ff;
   logic                   out_last_ff;

   logic                   fresh_clear;
   logic                   cur_reading;
   logic [ZC_WIDTH-1:0]    cur_zc, zc_inc;
   logic [BL_WIDTH-1:0]    cur_bl, bl_dec;
   logic [VALUE_WIDTH-1:0] cur_acc, acc_shift;
   logic [2:0]             eff_pos;
   logic                   data_bit;
   logic                   emit;
   logic                   code_ovf;
   logic [VALUE_WIDTH-1:0] code_value;
   logic [VALUE_WIDTH-1:0] map_value;
   logic                   map_delim;
   logic                   end_of_byte;
   logic                   out_free;
   logic                   push;
   logic                   can_go;
   logic                   step;

   always_comb begin
      fresh_clear = !started_ff && head.item.clear;
      cur_reading = fresh_clear ? 1'b0 : reading_ff;
      cur_zc      = fresh_clear ? '0 : zc_ff;
      cur_bl      = fresh_clear ? '0 : bl_ff;
      cur_acc     = fresh_clear ? '0 : acc_ff;
      eff_pos     = started_ff ? pos_ff : head.item.start_pos;
      data_bit    = head.item.data[LAST_POS - eff_pos];
      end_of_byte = (eff_pos == LAST_POS);
      zc_inc      = cur_zc + 1'b1;
      bl_dec      = cur_bl - 1'b1;
      acc_shift   = {cur_acc[VALUE_WIDTH-2:0], data_bit};
   end

   always_comb begin
      reading_in = cur_reading;
      zc_in      = cur_zc;
      bl_in      = cur_bl;
      acc_in     = cur_acc;
      emit       = 1'b0;
      code_ovf   = 1'b0;
      code_value = '0;
      if (!cur_reading) begin
         if (!data_bit) begin
            if (zc_inc > ZC_LIMIT) begin
               emit     = 1'b1;
               code_ovf = 1'b1;
               zc_in    = '0;
            end else begin
               zc_in = zc_inc;
            end
         end else if (cur_zc == '0) begin
            emit       = 1'b1;
            code_value = VALUE_ONE;
         end else begin
            reading_in = 1'b1;
            bl_in      = cur_zc[BL_WIDTH-1:0];
            acc_in     = VALUE_ONE;
         end
      end else begin
         if (bl_dec == '0) begin
            emit       = 1'b1;
            code_value = acc_shift;
            reading_in = 1'b0;
            zc_in      = '0;
            bl_in      = '0;
            acc_in     = '0;
         end else begin
            acc_in = acc_shift;
            bl_in  = bl_dec;
         end
      end
      if (end_of_byte && head.item.last) begin
         reading_in = 1'b0;
         zc_in      = '0;
         bl_in      = '0;
         acc_in     = '0;
      end
   end

   always_comb begin
      map_delim = 1'b0;
      if (code_ovf) begin
         map_value = '0;
      end else if (map_mode == MAP_OFFSET) begin
         if (code_value == VALUE_ONE) begin
            map_value = '1;
            map_delim = 1'b1;
         end else begin
            map_value = code_value - VALUE_TWO;
         end
      end else begin
         map_value = code_value;
      end
   end

   assign out_free = !out_valid_ff || !rsp_stall;
   assign push     = pend_valid_ff && out_free && (pend_end_ff || (head.valid && emit));
   assign can_go   = !emit || !pend_valid_ff || push;
   assign step     = head.valid && can_go;
   assign head_pop = step && end_of_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         reading_ff <= 1'b0;
         zc_ff      <= '0;
         bl_ff      <= '0;
         acc_ff     <= '0;
         started_ff <= 1'b0;
         pos_ff     <= '0;
      end else if (step) begin
         reading_ff <= reading_in;
         zc_ff      <= zc_in;
         bl_ff      <= bl_in;
         acc_ff     <= acc_in;
         started_ff <= !end_of_byte;
         pos_ff     <= eff_pos + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_end_ff   <= 1'b0;
      end else if (step && emit) begin
         pend_valid_ff <= 1'b1;
         pend_end_ff   <= end_of_byte;
      end else if (push) begin
         pend_valid_ff <= 1'b0;
      end else if (step && end_of_byte && pend_valid_ff) begin
         pend_end_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         pend_value_ff <= map_value;
         pend_delim_ff <= map_delim;
         pend_ovf_ff   <= code_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (push) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         out_value_ff <= pend_value_ff;
         out_delim_ff <= pend_delim_ff;
         out_ovf_ff   <= pend_ovf_ff;
         out_last_ff  <= pend_end_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_value          = out_value_ff;
   assign rsp_is_delimiter   = out_delim_ff;
   assign rsp_overflow_error = out_ovf_ff;
   assign rsp_last_of_run    = out_last_ff;

endmodule

// ----- rtl/elias_gamma_bit_decoder_core.sv -----
// Elias gamma decoder: takes one compressed byte per word on the req_ channel and walks its
// bits from the most significant down, one bit per clock while a waiting result does not stall
// the walker, skipping the first start_bit_skip bits of a restart byte; a two-word queue in front of the
// walker takes new bytes while it works. Each completed code becomes one word on the rsp_
// channel, at most one per cycle; a result waits in a one-word holding register until the next
// code of its byte completes or the last bit of its byte is walked, so that last_of_run can be
// set on the final result of its byte, and a byte that completes no code gives no word. Write
// map_mode through the csr_ port only while the block is idle.
module elias_gamma_bit_decoder_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_map_mode,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_restart,
   input  logic [2:0]                      req_start_bit_skip,
   input  logic                            req_last_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [egd_pkg::VALUE_WIDTH-1:0] rsp_value,
   output logic                            rsp_is_delimiter,
   output logic                            rsp_overflow_error,
   output logic                            rsp_last_of_run
);
   import egd_pkg::*;

   logic     map_mode_ff;
   head_type head;
   logic     head_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_mode_ff <= MAP_RESET;
      end else if (csr_valid && csr_ready) begin
         map_mode_ff <= csr_map_mode;
      end
   end

   egd_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_restart        (req_restart),
      .req_start_bit_skip (req_start_bit_skip),
      .req_last_byte      (req_last_byte),
      .head               (head),
      .head_pop           (head_pop)
   );

   egd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .map_mode           (map_mode_ff),
      .head               (head),
      .head_pop           (head_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_value          (rsp_value),
      .rsp_is_delimiter   (rsp_is_delimiter),
      .rsp_overflow_error (rsp_overflow_error),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow_error |-> rsp_value == '0)
      else $error("overflow word with nonzero value");

   a_delim_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_delimiter |-> rsp_value == '1 && !rsp_overflow_error)
      else $error("delimiter word malformed");

   a_delim_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_delimiter |-> map_mode_ff == MAP_OFFSET)
      else $error("delimiter in raw mode");

   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result word straight after reset");

endmodule

// ----- sim/tb_elias_gamma_bit_decoder_core.sv -----
`timescale 1ns / 100ps

module tb_elias_gamma_bit_decoder_core;
   import egd_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int SETTLE_TICKS    = 40;
   localparam int PHASES          = 8;
   localparam int BYTES_PER_PHASE = 64;
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      logic [7:0] data;
      logic       restart;
      logic [2:0] skip;
      logic       last;
   } byte_word_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic                   delim;
      logic                   ovf;
      logic                   last;
   } code_word_type;

   logic                   clock              = 1'b0;
   logic                   reset              = 1'b1;
   logic                   csr_valid          = 1'b0;
   logic                   csr_ready;
   logic                   csr_map_mode       = MAP_RESET;
   logic                   req_valid          = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_data_byte      = '0;
   logic                   req_restart        = 1'b0;
   logic [2:0]             req_start_bit_skip = '0;
   logic                   req_last_byte      = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall          = 1'b0;
   logic [VALUE_WIDTH-1:0] rsp_value;
   logic                   rsp_is_delimiter;
   logic                   rsp_overflow_error;
   logic                   rsp_last_of_run;

   byte_word_type byte_q[$];
   code_word_type decoded_q[$];
   bit            code_bits[$];

   logic                   map_mode_sh = MAP_RESET;
   logic                   in_payload  = 1'b0;
   logic [ZC_WIDTH-1:0]    zeros_seen  = '0;
   logic [BL_WIDTH-1:0]    payload_left = '0;
   logic [VALUE_WIDTH-1:0] acc         = '0;

   int idle_phase     = 0;
   int cycle_count    = 0;
   int mismatch_count = 0;
   int bytes_taken    = 0;
   int words_seen     = 0;
   int delim_seen     = 0;
   int ovf_seen       = 0;

   elias_gamma_bit_decoder_core dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_map_mode       (csr_map_mode),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_restart        (req_restart),
      .req_start_bit_skip (req_start_bit_skip),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_value          (rsp_value),
      .rsp_is_delimiter   (rsp_is_delimiter),
      .rsp_overflow_error (rsp_overflow_error),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic int sender_pct();
      return (idle_phase == 1) ? 64 : (idle_phase == 3) ? 23 : 0;
   endfunction

   function automatic int receiver_pct();
      return (idle_phase == 2) ? 64 : (idle_phase == 3) ? 23 : 0;
   endfunction

   task automatic clear_walker();
      in_payload   = 1'b0;
      zeros_seen   = '0;
      payload_left = '0;
      acc          = '0;
   endtask

   function automatic code_word_type map_code(input logic [VALUE_WIDTH-1:0] v);
      code_word_type w;
      w = '0;
      if (map_mode_sh == MAP_OFFSET && v == VALUE_ONE) begin
         w.value = '1;
         w.delim = 1'b1;
      end else if (map_mode_sh == MAP_OFFSET) begin
         w.value = v - VALUE_TWO;
      end else begin
         w.value = v;
      end
      return w;
   endfunction

   task automatic gamma_decode_byte(input byte_word_type w);
      code_word_type outs[8];
      int            n;
      int            pos;
      logic          b;
      n = 0;
      pos = 0;
      if (w.restart) begin
         clear_walker();
         pos = int'(w.skip);
      end
      for (; pos < 8; pos++) begin
         b = w.data[7 - pos];
         if (!in_payload) begin
            if (!b) begin
               zeros_seen = zeros_seen + 1'b1;
               if (zeros_seen > ZC_LIMIT) begin
                  outs[n] = '0;
                  outs[n].ovf = 1'b1;
                  n++;
                  clear_walker();
               end
            end else if (zeros_seen == '0) begin
               outs[n] = map_code(VALUE_ONE);
               n++;
               clear_walker();
            end else begin
               in_payload   = 1'b1;
               payload_left = zeros_seen[BL_WIDTH-1:0];
               acc          = VALUE_ONE;
            end
         end else begin
            acc          = {acc[VALUE_WIDTH-2:0], b};
            payload_left = payload_left - 1'b1;
            if (payload_left == '0) begin
               outs[n] = map_code(acc);
               n++;
               clear_walker();
            end
         end
      end
      if (w.last) begin
         clear_walker();
      end
      if (n > 0) begin
         outs[n-1].last = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
         decoded_q.push_back(outs[i]);
      end
   endtask

   task automatic push_byte(input logic [7:0] d, input logic r, input logic [2:0] s,
                            input logic l);
      byte_word_type w;
      w.data    = d;
      w.restart = r;
      w.skip    = s;
      w.last    = l;
      byte_q.push_back(w);
   endtask

   task automatic append_code();
      int zeros;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         zeros = $urandom_range(0, 3);
      end else if (pick < 85) begin
         zeros = $urandom_range(4, 15);
      end else if (pick < 97) begin
         zeros = $urandom_range(16, VALUE_WIDTH - 1);
      end else begin
         zeros = $urandom_range(VALUE_WIDTH, VALUE_WIDTH + 36);
      end
      for (int i = 0; i < zeros; i++) begin
         code_bits.push_back(1'b0);
      end
      if (zeros < VALUE_WIDTH) begin
         code_bits.push_back(1'b1);
         for (int i = 0; i < zeros; i++) begin
            code_bits.push_back(1'($urandom_range(0, 1)));
         end
      end
   endtask

   task automatic queue_stream_byte();
      byte_word_type w;
      w.restart = ($urandom_range(0, 15) == 0);
      w.skip    = 3'($urandom_range(0, 7));
      w.last    = ($urandom_range(0, 24) == 0);
      // realign the code stream after the skipped bits
      if (w.restart) begin
         code_bits.delete();
         for (int i = 0; i < int'(w.skip); i++) begin
            code_bits.push_back(1'($urandom_range(0, 1)));
         end
      end
      if ($urandom_range(0, 9) == 0) begin
         w.data = 8'($urandom_range(0, 255));
      end else begin
         while (code_bits.size() < 8) begin
            append_code();
         end
         for (int i = 0; i < 8; i++) begin
            w.data[7 - i] = code_bits.pop_front();
         end
      end
      if (w.last) begin
         code_bits.delete();
      end
      byte_q.push_back(w);
   endtask

   task automatic drain();
      while (byte_q.size() != 0 || req_valid || decoded_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_map_mode(input logic m);
      @(posedge clock);
      csr_valid    <= 1'b1;
      csr_map_mode <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      map_mode_sh = m;
   endtask

   always @(posedge clock) begin
      byte_word_type cur;
      byte_word_type nxt;
      bit            free;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         free = !req_valid;
         if (req_valid && !req_stall) begin
            cur.data    = req_data_byte;
            cur.restart = req_restart;
            cur.skip    = req_start_bit_skip;
            cur.last    = req_last_byte;
            gamma_decode_byte(cur);
            bytes_taken++;
            free = 1'b1;
         end
         // hold a stalled word, otherwise present the next one or idle
         if (free) begin
            if (byte_q.size() != 0 && $urandom_range(0, 99) >= sender_pct()) begin
               nxt = byte_q.pop_front();
               req_valid          <= 1'b1;
               req_data_byte      <= nxt.data;
               req_restart        <= nxt.restart;
               req_start_bit_skip <= nxt.skip;
               req_last_byte      <= nxt.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      code_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            words_seen++;
            if (decoded_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("unexpected word: value %h delim %b ovf %b last %b",
                           rsp_value, rsp_is_delimiter, rsp_overflow_error,
                           rsp_last_of_run);
               end
            end else begin
               want = decoded_q.pop_front();
               if (rsp_value !== want.value || rsp_is_delimiter !== want.delim ||
                   rsp_overflow_error !== want.ovf || rsp_last_of_run !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("word %0d: expected value %h delim %b ovf %b last %b",
                              words_seen, want.value, want.delim, want.ovf, want.last);
                     $display("word %0d:   actual value %h delim %b ovf %b last %b",
                              words_seen, rsp_value, rsp_is_delimiter,
                              rsp_overflow_error, rsp_last_of_run);
                  end
               end
               if (want.delim) begin
                  delim_seen++;
               end
               if (want.ovf) begin
                  ovf_seen++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_pct());
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timed out with %0d words outstanding", decoded_q.size());
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      logic m;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // a full byte of one-bit codes
      push_byte(8'hFF, 1'b1, 3'd0, 1'b0);
      // sixty-four zeros: overflow on the last bit
      repeat (8) push_byte(8'h00, 1'b0, 3'd0, 1'b0);
      // widest code: 63 zeros, the leading one, 63 payload ones
      repeat (7) push_byte(8'h00, 1'b0, 3'd0, 1'b0);
      push_byte(8'h01, 1'b0, 3'd0, 1'b0);
      repeat (8) push_byte(8'hFF, 1'b0, 3'd0, 1'b0);
      push_byte(8'hA7, 1'b1, 3'd5, 1'b0);
      // unfinished code dropped at the final byte
      push_byte(8'h02, 1'b0, 3'd6, 1'b1);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         idle_phase = p % 4;
         m = (((p ^ (p >> 2)) & 1) != 0) ? MAP_OFFSET : MAP_RAW;
         write_map_mode(m);
         repeat (BYTES_PER_PHASE) queue_stream_byte();
         drain();
      end

      $display("Decoded %0d compressed bytes into %0d result words",
               bytes_taken, words_seen);
      $display("(%0d delimiters, %0d overflows) in both map modes under free flow, %s",
               delim_seen, ovf_seen, "sender gaps, receiver stalls and both");
      if (mismatch_count == 0 && decoded_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d words outstanding", mismatch_count, decoded_q.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
